>>> rtl/bac_pkg.sv
// bac_pkg: shared types, constants and operation/status codes for the
// bounded bump allocator with guarded byte store. no dependencies.
`timescale 1ns / 1ps
package bac_pkg;
  localparam int MaxRegions = 64;
  localparam int StoreBytes = 65536;
  localparam int RegW = $clog2(MaxRegions);
  localparam int CntW = $clog2(MaxRegions + 1);
  localparam int StoreW = $clog2(StoreBytes);
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_EXHAUST  = 2'd3
  } status_t;

  // classified item passed from front to back
  typedef struct packed {
    op_t         op;
    logic [31:0] start_address;
    logic [16:0] length;
    logic [15:0] byte_offset;
    logic [15:0] alignment;
    logic [7:0]  write_data;
    logic        zero_len;
    logic        off_bad;
  } item_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_ACHK, S_SCAN, S_SCHK, S_MEM, S_MEMW, S_OUT
  } state_t;
endpackage

>>> rtl/bump_allocator_bounds_checked_store.sv
// bump_allocator_bounds_checked_store: top level, front classifier plus back executor.
// depends on bac_pkg, bac_front, bac_back.
`timescale 1ns / 1ps
// After reset the byte store is cleared one byte per cycle; until that pass is done
// at most two input transactions are taken into the queue and none is executed,
// configuration writes are taken at any time.
// An allocate runs the 32-step bit-serial remainder of the free pointer by the
// alignment; a read or write runs the region table scan (one entry per cycle, up
// to 64) and then the store port access.
// A two-entry queue lets input transactions be taken while the back end works.
module bump_allocator_bounds_checked_store (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[1:0], start_address[33:2], length[50:34], byte_offset[66:51],
  // alignment[82:67], write_data[90:83], zero pad to 96
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], allocated_base[33:2], read_data[41:34], zero pad to 48
  output logic [47:0] m_tdata
);
  logic q_valid, q_pop;
  bac_pkg::item_t q_item;
  logic [1:0] status;
  logic [31:0] allocated_base;
  logic [7:0] read_data;

  assign cfg_ready = 1'b1;
  assign m_tdata = {6'd0, read_data, allocated_base, status};

  bac_front u_front (
    .clk, .rst, .s_tvalid, .s_tready,
    .operation(s_tdata[1:0]), .start_address(s_tdata[33:2]), .length(s_tdata[50:34]),
    .byte_offset(s_tdata[66:51]), .alignment(s_tdata[82:67]),
    .write_data(s_tdata[90:83]),
    .q_valid, .q_pop, .q_item
  );

  bac_back u_back (
    .clk, .rst, .cfg_valid, .cfg_data, .q_valid, .q_pop, .q_item,
    .m_tvalid, .m_tready, .status, .allocated_base, .read_data
  );
endmodule

>>> rtl/bac_front.sv
// bac_front: accepts input transactions, classifies them and queues them.
// depends on bac_pkg.
`timescale 1ns / 1ps
module bac_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [1:0]     operation,
  input  logic [31:0]    start_address,
  input  logic [16:0]    length,
  input  logic [15:0]    byte_offset,
  input  logic [15:0]    alignment,
  input  logic [7:0]     write_data,
  output logic           q_valid,
  input  logic           q_pop,
  output bac_pkg::item_t q_item
);
  bac_pkg::item_t mem [bac_pkg::QDepth];
  logic wp, rp;
  logic [1:0] cnt;
  bac_pkg::item_t it;
  logic push;

  always_comb begin
    it.op = bac_pkg::op_t'(operation);
    it.start_address = start_address;
    it.length = length;
    it.byte_offset = byte_offset;
    it.alignment = alignment;
    it.write_data = write_data;
    it.zero_len = (length == 17'd0);
    it.off_bad = ({1'b0, byte_offset} >= length);
  end

  assign s_tready = (cnt != 2'd2);
  assign push = s_tvalid && s_tready;
  assign q_valid = (cnt != 2'd0);
  assign q_item = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= it;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> cnt != 2'd2)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> cnt != 2'd0)
    else $error("queue underflow");
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (!push && !q_pop) |=> $stable(cnt)) else $error("queue count moved");
endmodule

>>> rtl/bac_back.sv
// bac_back: executes queued items: alignment division, region scan, byte store.
// depends on bac_pkg.
`timescale 1ns / 1ps
module bac_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  input  logic [31:0]    cfg_data,
  input  logic           q_valid,
  output logic           q_pop,
  input  bac_pkg::item_t q_item,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [1:0]     status,
  output logic [31:0]    allocated_base,
  output logic [7:0]     read_data
);
  bac_pkg::state_t state, state_next;
  logic [31:0] heap_base, nfa;
  logic [bac_pkg::CntW-1:0] rcount;
  logic [31:0] rbase [bac_pkg::MaxRegions];
  logic [16:0] rsize [bac_pkg::MaxRegions];
  logic [7:0] store [bac_pkg::StoreBytes];
  logic [bac_pkg::StoreW:0] clr;
  bac_pkg::item_t cur;
  // restoring divider for nfa % alignment
  logic [31:0] dq;
  logic [15:0] drem;
  logic [5:0] dcnt;
  logic [16:0] dtrial;
  logic [15:0] align1;
  logic [32:0] vbase;
  logic [33:0] aend;
  logic [bac_pkg::RegW:0] si;
  logic [31:0] sb;
  logic [16:0] ss;
  logic [32:0] bend, send;
  logic found, in_win;
  logic [32:0] baddr, boff33;
  logic [bac_pkg::StoreW-1:0] sidx;
  logic [7:0] rdq;

  assign align1 = (cur.alignment == 16'd0) ? 16'd1 : cur.alignment;
  assign dtrial = {drem, dq[31]} - {1'b0, align1};
  assign aend = {1'b0, vbase} + ((cur.length == 17'd0) ? 34'd1 : {17'd0, cur.length});
  assign bend = {1'b0, cur.start_address} + {16'd0, cur.length};
  assign send = {1'b0, sb} + {16'd0, ss};
  assign baddr = {1'b0, cur.start_address} + {17'd0, cur.byte_offset};
  assign boff33 = baddr - {1'b0, heap_base};
  assign in_win = (baddr >= {1'b0, heap_base}) && (boff33 < 33'(bac_pkg::StoreBytes));
  assign sidx = boff33[bac_pkg::StoreW-1:0];
  assign q_pop = (state == bac_pkg::S_IDLE) && q_valid && !m_tvalid;

  always_comb begin
    state_next = state;
    case (state)
      bac_pkg::S_CLEAR: if (clr[bac_pkg::StoreW]) state_next = bac_pkg::S_IDLE;
      bac_pkg::S_IDLE: if (q_pop) begin
        case (q_item.op)
          bac_pkg::OP_ALLOC: state_next = (rcount == bac_pkg::CntW'(bac_pkg::MaxRegions))
                                          ? bac_pkg::S_OUT : bac_pkg::S_DIV;
          bac_pkg::OP_WRITE, bac_pkg::OP_READ:
            state_next = q_item.zero_len ? bac_pkg::S_OUT : bac_pkg::S_SCAN;
          default: state_next = bac_pkg::S_OUT;
        endcase
      end
      bac_pkg::S_DIV: if (dcnt == 6'd32) state_next = bac_pkg::S_ACHK;
      bac_pkg::S_ACHK: state_next = bac_pkg::S_OUT;
      bac_pkg::S_SCAN: state_next = (found || si >= (bac_pkg::RegW+1)'(rcount))
                                    ? bac_pkg::S_SCHK : bac_pkg::S_SCAN;
      bac_pkg::S_SCHK: state_next = (found && !cur.off_bad) ? bac_pkg::S_MEM : bac_pkg::S_OUT;
      bac_pkg::S_MEM: state_next = bac_pkg::S_MEMW;
      bac_pkg::S_MEMW: state_next = bac_pkg::S_OUT;
      bac_pkg::S_OUT: state_next = bac_pkg::S_IDLE;
      default: state_next = bac_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == bac_pkg::S_CLEAR) store[clr[bac_pkg::StoreW-1:0]] <= 8'd0;
    else if (state == bac_pkg::S_MEM && in_win && cur.op == bac_pkg::OP_WRITE)
      store[sidx] <= cur.write_data;
    rdq <= store[sidx];
  end

  always_ff @(posedge clk) begin
    if (state == bac_pkg::S_SCAN) begin
      sb <= rbase[si[bac_pkg::RegW-1:0]];
      ss <= rsize[si[bac_pkg::RegW-1:0]];
    end
    if (state == bac_pkg::S_ACHK && status == bac_pkg::ST_OK) begin
      rbase[rcount[bac_pkg::RegW-1:0]] <= vbase[31:0];
      rsize[rcount[bac_pkg::RegW-1:0]] <= cur.length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bac_pkg::S_CLEAR;
      clr <= '0;
      heap_base <= 32'd0;
      nfa <= 32'd0;
      rcount <= '0;
      m_tvalid <= 1'b0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bac_pkg::S_CLEAR) clr <= clr + (bac_pkg::StoreW+1)'(1);
      if (cfg_valid) begin
        heap_base <= cfg_data;
        nfa <= cfg_data;
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        bac_pkg::S_IDLE: if (q_pop) begin
          cur <= q_item;
          status <= bac_pkg::ST_OK;
          allocated_base <= 32'd0;
          read_data <= 8'd0;
          dq <= nfa;
          drem <= 16'd0;
          dcnt <= 6'd0;
          si <= '0;
          found <= 1'b0;
          if (q_item.op == bac_pkg::OP_ALLOC &&
              rcount == bac_pkg::CntW'(bac_pkg::MaxRegions)) status <= bac_pkg::ST_FULL;
        end
        bac_pkg::S_DIV: if (dcnt != 6'd32) begin
          if (!dtrial[16]) drem <= dtrial[15:0];
          else drem <= {drem[14:0], dq[31]};
          dq <= {dq[30:0], 1'b0};
          dcnt <= dcnt + 6'd1;
        end else begin
          vbase <= (drem == 16'd0) ? {1'b0, nfa}
                   : {1'b0, nfa} + {17'd0, align1 - drem};
        end
        bac_pkg::S_ACHK: begin
          if (aend > 34'hFFFFFFFF || aend[32:0] < {1'b0, heap_base} ||
              aend[32:0] - {1'b0, heap_base} > 33'(bac_pkg::StoreBytes))
            status <= bac_pkg::ST_EXHAUST;
          else begin
            rcount <= rcount + bac_pkg::CntW'(1);
            nfa <= aend[31:0];
            allocated_base <= vbase[31:0];
          end
        end
        bac_pkg::S_SCAN: begin
          // entry read this cycle is compared next cycle
          if (si != '0 && {1'b0, cur.start_address} >= {1'b0, sb} && bend <= send)
            found <= 1'b1;
          si <= si + (bac_pkg::RegW+1)'(1);
        end
        bac_pkg::S_SCHK: begin
          if (!found) begin
            if ({1'b0, cur.start_address} >= {1'b0, sb} && bend <= send &&
                si <= (bac_pkg::RegW+1)'(rcount) && si != '0) found <= 1'b1;
          end
        end
        bac_pkg::S_MEMW: if (cur.op == bac_pkg::OP_READ && in_win) read_data <= rdq;
        bac_pkg::S_OUT: m_tvalid <= 1'b1;
        default: ;
      endcase
      if (state == bac_pkg::S_SCHK) begin
        if (!(found || ({1'b0, cur.start_address} >= {1'b0, sb} && bend <= send &&
              si <= (bac_pkg::RegW+1)'(rcount) && si != '0)) || cur.off_bad)
          status <= bac_pkg::ST_RANGE;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    rcount <= bac_pkg::CntW'(bac_pkg::MaxRegions)) else $error("region count overflow");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !m_tvalid) else $error("pop while result pending");
endmodule

>>> verif/bac_checker.sv
// bac_checker: watches the configuration, input and result channels of the allocator,
// predicts every result and compares it field by field. depends on bac_pkg.
`timescale 1ns / 1ps
module bac_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  output int unsigned outstanding,
  output int unsigned errors
);
  typedef struct packed {
    bac_pkg::status_t status;
    logic [31:0]      base;
    logic [7:0]       rdata;
  } result_t;

  result_t     due_results[$];
  logic [31:0] heap_base_q;
  logic [31:0] free_ptr;
  logic [31:0] reg_base [bac_pkg::MaxRegions];
  logic [16:0] reg_size [bac_pkg::MaxRegions];
  int unsigned reg_count;
  logic [7:0]  mem [bac_pkg::StoreBytes];

  initial begin
    errors = 0;
    outstanding = 0;
    for (int i = 0; i < bac_pkg::StoreBytes; i++) mem[i] = 8'd0;
  end

  function automatic bit fits_region(logic [63:0] addr, logic [63:0] len);
    logic [63:0] b;
    if (len == 0) return 1'b1;
    for (int i = 0; i < reg_count; i++) begin
      b = {32'd0, reg_base[i]};
      if (addr >= b && addr + len <= b + {47'd0, reg_size[i]}) return 1'b1;
    end
    return 1'b0;
  endfunction

  // updates the allocator state and returns the result of one item
  function automatic result_t predict_result(logic [95:0] d);
    bac_pkg::op_t op;
    logic [63:0]  addr, len, boff, align, v, rem, fin, idx;
    logic [7:0]   wd;
    result_t      res;
    op    = bac_pkg::op_t'(d[1:0]);
    addr  = {32'd0, d[33:2]};
    len   = {47'd0, d[50:34]};
    boff  = {48'd0, d[66:51]};
    align = {48'd0, d[82:67]};
    wd    = d[90:83];
    res   = '{status: bac_pkg::ST_OK, base: 32'd0, rdata: 8'd0};
    if (op == bac_pkg::OP_ALLOC) begin
      if (reg_count >= bac_pkg::MaxRegions) begin
        res.status = bac_pkg::ST_FULL;
      end else begin
        if (align == 0) align = 1;
        v = {32'd0, free_ptr};
        rem = v % align;
        if (rem != 0) v = v + align - rem;
        fin = v + ((len == 0) ? 64'd1 : len);
        if (fin > 64'hFFFF_FFFF || fin < {32'd0, heap_base_q} ||
            fin - {32'd0, heap_base_q} > 64'(bac_pkg::StoreBytes)) begin
          res.status = bac_pkg::ST_EXHAUST;
        end else begin
          reg_base[reg_count] = v[31:0];
          reg_size[reg_count] = len[16:0];
          reg_count++;
          free_ptr = fin[31:0];
          res.base = v[31:0];
        end
      end
    end else if (op == bac_pkg::OP_WRITE || op == bac_pkg::OP_READ) begin
      if (!fits_region(addr, len)) begin
        res.status = bac_pkg::ST_RANGE;
      end else if (len != 0) begin
        if (boff >= len) begin
          res.status = bac_pkg::ST_RANGE;
        end else begin
          idx = addr + boff;
          if (idx >= {32'd0, heap_base_q} &&
              idx - {32'd0, heap_base_q} < 64'(bac_pkg::StoreBytes)) begin
            idx = idx - {32'd0, heap_base_q};
            if (op == bac_pkg::OP_WRITE) mem[idx] = wd;
            else res.rdata = mem[idx];
          end
        end
      end
    end
    return res;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      heap_base_q = 32'd0;
      free_ptr    = 32'd0;
      reg_count   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        heap_base_q = cfg_data;
        free_ptr    = cfg_data;
      end
      if (s_tvalid && s_tready)
        due_results.insert(due_results.size(), predict_result(s_tdata));
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          report("unexpected result transaction", m_tdata[31:0], 32'd0);
        end else begin
          want = due_results.pop_front();
          if (m_tdata[1:0] != want.status)
            report("status", 32'(m_tdata[1:0]), 32'(want.status));
          if (m_tdata[33:2] != want.base) report("allocated_base", m_tdata[33:2], want.base);
          if (m_tdata[41:34] != want.rdata)
            report("read_data", 32'(m_tdata[41:34]), 32'(want.rdata));
          if (m_tdata[47:42] != 6'd0) report("pad bits", 32'(m_tdata[47:42]), 32'd0);
        end
      end
    end
    outstanding <= due_results.size();
  end
endmodule

>>> verif/testbench.sv
// testbench: clock, reset and stimulus for bump_allocator_bounds_checked_store,
// with bac_checker beside the block giving the mismatch count. depends on bac_pkg.
`timescale 1ns / 1ps
module testbench;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = 32'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = 96'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  int unsigned outstanding, errors;

  bit           calm = 1'b0;
  int unsigned  sent = 0;
  int unsigned  quiet = 0;
  int unsigned  ready_left = 0;
  bac_pkg::op_t sent_ops[$];
  logic [16:0]  sent_lens[$];
  logic [31:0]  known_base[$];
  logic [16:0]  known_size[$];

  bump_allocator_bounds_checked_store i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  bac_checker i_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .outstanding(outstanding), .errors(errors)
  );

  always #5 clk = ~clk;

  // receiver stalls in bursts, never in the calm part
  always @(posedge clk) begin
    if (calm) begin
      m_tready <= 1'b1;
    end else if (ready_left == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        ready_left <= $urandom_range(1, 14);
      end else begin
        m_tready <= 1'b1;
        ready_left <= $urandom_range(1, 30);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  // learn granted regions so accesses can be aimed inside them
  always @(posedge clk) begin
    bac_pkg::op_t op;
    logic [16:0]  len;
    if (!rst && m_tvalid && m_tready && sent_ops.size() != 0) begin
      op = sent_ops.pop_front();
      len = sent_lens.pop_front();
      if (op == bac_pkg::OP_ALLOC && m_tdata[1:0] == bac_pkg::ST_OK) begin
        known_base.insert(known_base.size(), m_tdata[33:2]);
        known_size.insert(known_size.size(), len);
      end
    end
  end

  // limit covers the store clearing pass after reset
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > 200000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_heap_base(input logic [31:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send(input bac_pkg::op_t op, input logic [31:0] addr,
                      input logic [16:0] len, input logic [15:0] boff,
                      input logic [15:0] align, input logic [7:0] wd);
    s_tdata <= {5'd0, wd, align, boff, len, addr, op};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_ops.insert(sent_ops.size(), op);
    sent_lens.insert(sent_lens.size(), len);
    sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // drain, then let the back end settle before touching the register
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_items(input int unsigned count);
    int unsigned stop, k, sub, blen, p;
    logic [31:0] b;
    logic [16:0] sz;
    stop = sent + count;
    while (sent < stop) begin
      p = $urandom_range(0, 99);
      if (p < 12) begin
        send(bac_pkg::OP_ALLOC, $urandom,
             17'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65536)
                 : $urandom_range(0, 300)), 16'($urandom),
             ($urandom_range(0, 1) != 0) ? 16'(32'd1 << $urandom_range(0, 15))
             : 16'($urandom),
             8'($urandom));
      end else if (p < 82 && known_base.size() != 0) begin
        k = $urandom_range(0, known_base.size() - 1);
        b = known_base[k];
        sz = known_size[k];
        if (sz == 0) begin
          send(bac_pkg::op_t'($urandom_range(1, 2)), b, 17'd0, 16'($urandom),
               16'($urandom), 8'($urandom));
        end else begin
          sub = $urandom_range(0, sz - 1);
          blen = $urandom_range(1, (sz - sub > 8) ? 8 : sz - sub);
          for (int i = 0; i < blen; i++)
            send(bac_pkg::OP_WRITE, b + 32'(sub), 17'(blen), 16'(i), 16'($urandom),
                 8'($urandom));
          for (int i = 0; i < blen; i++)
            send(bac_pkg::OP_READ, b + 32'(sub), 17'(blen),
                 16'(($urandom_range(0, 7) == 0) ? blen : i), 16'($urandom),
                 8'($urandom));
        end
      end else begin
        send(bac_pkg::op_t'($urandom_range(0, 3)), $urandom,
             17'($urandom_range(0, 65536)), 16'($urandom), 16'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    write_heap_base(32'd0);
    send(bac_pkg::OP_ALLOC, 32'd0, 17'd0, 16'd0, 16'd0, 8'd0);   // base 0, pointer moves by 1
    send(bac_pkg::OP_ALLOC, 32'hFFFF_FFFF, 17'd5, 16'hFFFF, 16'd3, 8'hFF); // base 3
    send(bac_pkg::OP_ALLOC, 32'd0, 17'd100, 16'd0, 16'd16, 8'd0); // base 16
    send(bac_pkg::OP_WRITE, 32'd3, 17'd5, 16'd0, 16'd0, 8'hFF);
    send(bac_pkg::OP_WRITE, 32'd3, 17'd5, 16'd4, 16'hFFFF, 8'h5A);
    send(bac_pkg::OP_READ, 32'd3, 17'd5, 16'd0, 16'd0, 8'd0);
    send(bac_pkg::OP_READ, 32'd3, 17'd5, 16'd4, 16'd0, 8'd0);
    send(bac_pkg::OP_READ, 32'd16, 17'd100, 16'd0, 16'd0, 8'd0);  // never written
    send(bac_pkg::OP_READ, 32'd3, 17'd5, 16'd5, 16'd0, 8'd0);     // offset past burst
    send(bac_pkg::OP_WRITE, 32'h1234, 17'd0, 16'd7, 16'd0, 8'h11); // zero-length burst
    send(bac_pkg::OP_READ, 32'd3, 17'd20, 16'd0, 16'd0, 8'd0);    // spans two regions
    send(bac_pkg::OP_NONE, 32'hFFFF_FFFF, 17'h1FFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send(bac_pkg::OP_ALLOC, 32'd0, 17'd65536, 16'd0, 16'd1, 8'd0); // does not fit
    settle();

    write_heap_base(32'h8000_0000);
    send(bac_pkg::OP_ALLOC, 32'd0, 17'd65536, 16'd0, 16'h8000, 8'd0); // whole store
    send(bac_pkg::OP_WRITE, 32'h8000_0000, 17'd65536, 16'hFFFF, 16'd0, 8'hA5);
    send(bac_pkg::OP_READ, 32'h8000_0000, 17'd65536, 16'hFFFF, 16'd0, 8'd0);
    send(bac_pkg::OP_READ, 32'd3, 17'd5, 16'd4, 16'd0, 8'd0);     // outside the window now
    send(bac_pkg::OP_ALLOC, 32'd0, 17'd1, 16'd0, 16'hFFFF, 8'd0);
    settle();

    write_heap_base($urandom);
    random_items(90);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    random_items(90);
    settle();

    write_heap_base(32'hFFFF_FFFF);
    send(bac_pkg::OP_ALLOC, 32'd0, 17'd0, 16'd0, 16'd0, 8'd0);    // end reaches 2^32
    random_items(50);
    settle();

    calm = 1'b1;
    write_heap_base(32'd0);
    for (int i = 0; i < 70; i++) send(bac_pkg::OP_ALLOC, 32'd0, 17'd1, 16'd0, 16'd1, 8'd0);
    random_items(100);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> bump_allocator_bounds_checked_store.f
rtl/bac_pkg.sv
rtl/bac_front.sv
rtl/bac_back.sv
rtl/bump_allocator_bounds_checked_store.sv
verif/bac_checker.sv
verif/testbench.sv
